>>> rtl/core/runlevel_callback_queue_pool_macros.svh
// Assertion macros shared by the callback queue pool.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RUNLEVEL_CALLBACK_QUEUE_POOL_MACROS_SVH
`define RUNLEVEL_CALLBACK_QUEUE_POOL_MACROS_SVH

`ifndef ASSERT_OFF

// A condition that holds at every clock edge outside reset.
`define RCQP_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// A condition that implies another in the same cycle.
`define RCQP_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// A condition that implies another in the following cycle.
`define RCQP_IMPLIES_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define RCQP_CHECK(lbl, expr)
`define RCQP_IMPLIES(lbl, ante, cons)
`define RCQP_IMPLIES_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/core/rcqp_pkg.sv
`timescale 1ns / 1ps

package rcqp_pkg;

  // Width of the handle field on both channels.
  localparam int HANDLE_W = 32;

  // Command codes carried in the cmd field.
  localparam logic CMD_POST = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // List selector codes.
  typedef enum logic [1:0] {
    LIST_INIT        = 2'd0,
    LIST_SHUTDOWN    = 2'd1,
    LIST_BEFORE_EXIT = 2'd2,
    LIST_AFTER_EXIT  = 2'd3
  } list_sel_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_CALL   = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_POST2,
    S_RD,
    S_WALK,
    S_DONE
  } back_state_t;

  // One classified command as it waits between front and back.
  typedef struct packed {
    logic                is_run;
    logic                is_init;
    logic [1:0]          sel;
    logic [HANDLE_W-1:0] handle;
    logic                skip;
    logic                abort;
  } cmd_item_t;

endpackage

>>> rtl/core/runlevel_callback_queue_pool.sv
`timescale 1ns / 1ps

// Callback queue pool: a pool of ENTRIES linked entries holds four callback
// lists (init runs first-in first-out; shutdown, before_exit and after_exit
// run last-in first-out) and a free list. A post (cmd 0) gives one result:
// kind 0 when stored, kind 1 when the pool is full. A run (cmd 1) gives one
// kind 2 result per called entry, then a kind 3 result with last set; every
// walked entry returns to the pool. Commands pass through a two-beat queue,
// so the input side can take one further command while the back end works.
// Each run step must wait for the registered read of the entry's link before
// the next entry is known. A stalled output holds the sequencer whenever it
// has a result to give. No clearing pass after reset: link memory valid bits
// stand in for the reset chain.
module runlevel_callback_queue_pool #(
  parameter int ENTRIES     = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [1:0]                    list_sel,
  input  logic [rcqp_pkg::HANDLE_W-1:0] handle,
  input  logic                          skip_on_abort,
  input  logic                          aborting,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [rcqp_pkg::HANDLE_W-1:0] out_handle,
  output logic                          last
);
  import rcqp_pkg::*;

  logic      q_valid;
  logic      q_pop;
  cmd_item_t q_item;

  // Front end: handshake, classification and command queue.
  rcqp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .list_sel      (list_sel),
    .handle        (handle),
    .skip_on_abort (skip_on_abort),
    .aborting      (aborting),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // Back end: pool memories, list sequencer and result register.
  rcqp_back #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_handle (out_handle),
    .last       (last)
  );

endmodule

>>> rtl/core/rcqp_front.sv
`timescale 1ns / 1ps
`include "runlevel_callback_queue_pool_macros.svh"

module rcqp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [1:0]                list_sel,
  input  logic [rcqp_pkg::HANDLE_W-1:0] handle,
  input  logic                      skip_on_abort,
  input  logic                      aborting,
  output logic                      q_valid,
  output rcqp_pkg::cmd_item_t       q_item,
  input  logic                      q_pop
);
  import rcqp_pkg::*;

  cmd_item_t  slot [2];
  cmd_item_t  item_in;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;

  // Classify the incoming beat.
  always_comb begin
    item_in.is_run  = (cmd == CMD_RUN);
    item_in.is_init = (list_sel == LIST_INIT);
    item_in.sel     = list_sel;
    item_in.handle  = handle;
    item_in.skip    = skip_on_abort;
    item_in.abort   = aborting;
  end

  // Two-slot queue towards the back end.
  assign in_ready = !rst && (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 2'd1;
    end else if (!push && q_pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  `RCQP_CHECK(a_count_bound, count <= 2'd2)
  `RCQP_IMPLIES(a_pop_nonempty, q_pop, count != 2'd0)
  `RCQP_IMPLIES_NEXT(a_push_grows, (!rst && push && !q_pop), count == $past(count) + 2'd1)

endmodule

>>> rtl/core/rcqp_back.sv
`timescale 1ns / 1ps
`include "runlevel_callback_queue_pool_macros.svh"

module rcqp_back #(
  parameter int ENTRIES     = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  rcqp_pkg::cmd_item_t           q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [rcqp_pkg::HANDLE_W-1:0] out_handle,
  output logic                          last
);
  import rcqp_pkg::*;

  localparam int IDX_W      = $clog2(ENTRIES + 1);
  localparam int ADDR_W     = $clog2(ENTRIES);
  localparam int STORE_BITS = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam logic [IDX_W-1:0] NIL = IDX_W'(ENTRIES);

  // Pool storage: link memory with per-entry valid bits, payload memories.
  logic [IDX_W-1:0]      next_mem   [ENTRIES];
  logic [ENTRIES-1:0]    next_ok;
  logic [STORE_BITS-1:0] handle_mem [ENTRIES];
  logic                  skip_mem   [ENTRIES];

  // Registered read port.
  logic [IDX_W-1:0]      rd_next;
  logic                  rd_ok;
  logic [STORE_BITS-1:0] rd_handle;
  logic                  rd_skip;
  logic [ADDR_W-1:0]     rd_addr;
  logic [IDX_W-1:0]      nxt_val;

  // Sequencer registers.
  back_state_t      state, state_next;
  logic [IDX_W-1:0] free_head, free_head_next;
  logic [IDX_W-1:0] head [4];
  logic [IDX_W-1:0] head_next [4];
  logic [IDX_W-1:0] init_tail, init_tail_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [IDX_W-1:0] steps, steps_next;
  logic [IDX_W-1:0] post_idx, post_idx_next;
  logic             need_link, need_link_next;
  logic [IDX_W-1:0] link_tail, link_tail_next;

  // Memory port controls.
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             nx_we;
  logic [IDX_W-1:0] nx_waddr;
  logic [IDX_W-1:0] nx_wdata;
  logic             h_we;
  logic             call;
  logic             full_post;

  // Output register.
  logic                  out_free;
  logic                  emit;
  kind_t                 emit_kind;
  logic [HANDLE_W-1:0]   emit_handle;
  logic                  emit_last;
  kind_t                 out_kind;
  logic [HANDLE_W-1:0]   out_handle_r;
  logic                  out_last;

  assign out_free   = !out_valid || out_ready;
  assign kind       = out_kind;
  assign out_handle = out_handle_r;
  assign last       = out_last;

  // An entry never written since reset still holds its reset link.
  assign nxt_val = rd_ok ? rd_next : (IDX_W'(rd_addr) + IDX_W'(1));
  assign call    = !(q_item.abort && rd_skip);

  // A post waiting at the head of the queue while the pool is exhausted.
  assign full_post = (state == S_IDLE) && q_valid && !q_item.is_run && (free_head >= NIL);

  // Next state, pointer updates and memory port controls.
  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    head_next      = head;
    init_tail_next = init_tail;
    cur_next       = cur;
    steps_next     = steps;
    post_idx_next  = post_idx;
    need_link_next = need_link;
    link_tail_next = link_tail;
    rd_en          = 1'b0;
    rd_idx         = cur;
    nx_we          = 1'b0;
    nx_waddr       = cur;
    nx_wdata       = free_head;
    h_we           = 1'b0;
    emit           = 1'b0;
    emit_kind      = KIND_ACCEPT;
    emit_handle    = '0;
    emit_last      = 1'b1;
    q_pop          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.is_run) begin
            // Detach the selected list and start the walk.
            cur_next               = head[q_item.sel];
            head_next[q_item.sel]  = NIL;
            if (q_item.is_init) begin
              init_tail_next = NIL;
            end
            steps_next = '0;
            state_next = S_RD;
          end else if (free_head >= NIL) begin
            // Pool exhausted: reject and leave the state alone.
            if (out_free) begin
              emit      = 1'b1;
              emit_kind = KIND_REJECT;
              q_pop     = 1'b1;
            end
          end else begin
            // Take the free head, fetch its link and fill the entry.
            rd_en         = 1'b1;
            rd_idx        = free_head;
            h_we          = 1'b1;
            nx_we         = 1'b1;
            nx_waddr      = free_head;
            post_idx_next = free_head;
            if (q_item.is_init) begin
              nx_wdata = NIL;
              if (head[0] >= NIL || init_tail >= NIL) begin
                head_next[0]   = free_head;
                need_link_next = 1'b0;
              end else begin
                need_link_next = 1'b1;
                link_tail_next = init_tail;
              end
              init_tail_next = free_head;
            end else begin
              nx_wdata               = head[q_item.sel];
              head_next[q_item.sel]  = free_head;
              need_link_next         = 1'b0;
            end
            state_next = S_POST2;
          end
        end
      end
      S_POST2: begin
        if (out_free) begin
          free_head_next = nxt_val;
          if (need_link) begin
            nx_we    = 1'b1;
            nx_waddr = link_tail;
            nx_wdata = post_idx;
          end
          emit       = 1'b1;
          emit_kind  = KIND_ACCEPT;
          q_pop      = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        if (cur >= NIL || steps == NIL) begin
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_idx     = cur;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (!call || out_free) begin
          if (call) begin
            emit        = 1'b1;
            emit_kind   = KIND_CALL;
            emit_handle = HANDLE_W'(rd_handle);
            emit_last   = 1'b0;
          end
          // Return the walked entry to the free list.
          nx_we          = 1'b1;
          nx_waddr       = cur;
          nx_wdata       = free_head;
          free_head_next = cur;
          cur_next       = nxt_val;
          steps_next     = steps + IDX_W'(1);
          state_next     = S_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_DONE;
          q_pop      = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer and list pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      for (int i = 0; i < 4; i++) begin
        head[i] <= NIL;
      end
      init_tail <= NIL;
      cur       <= NIL;
      steps     <= '0;
      need_link <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      head      <= head_next;
      init_tail <= init_tail_next;
      cur       <= cur_next;
      steps     <= steps_next;
      need_link <= need_link_next;
    end
  end

  always_ff @(posedge clk) begin
    post_idx  <= post_idx_next;
    link_tail <= link_tail_next;
  end

  // Link memory valid bits; reset marks every entry as holding its reset link.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_ok <= '0;
    end else if (nx_we) begin
      next_ok[nx_waddr[ADDR_W-1:0]] <= 1'b1;
    end
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_waddr[ADDR_W-1:0]] <= nx_wdata;
    end
    if (h_we) begin
      handle_mem[rd_idx[ADDR_W-1:0]] <= q_item.handle[STORE_BITS-1:0];
      skip_mem[rd_idx[ADDR_W-1:0]]   <= q_item.skip;
    end
    if (rd_en) begin
      rd_next   <= next_mem[rd_idx[ADDR_W-1:0]];
      rd_ok     <= next_ok[rd_idx[ADDR_W-1:0]];
      rd_handle <= handle_mem[rd_idx[ADDR_W-1:0]];
      rd_skip   <= skip_mem[rd_idx[ADDR_W-1:0]];
      rd_addr   <= rd_idx[ADDR_W-1:0];
    end
  end

  // Result register towards the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind     <= emit_kind;
      out_handle_r <= emit_handle;
      out_last     <= emit_last;
    end
  end

  `RCQP_IMPLIES_NEXT(a_full_rejects, (full_post && out_free), (out_valid && out_last))
  `RCQP_CHECK(a_steps_bound, steps <= NIL)
  `RCQP_IMPLIES_NEXT(a_pop_is_last, (!rst && q_pop), (out_valid && out_last))

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import rcqp_pkg::*;

  localparam int         POOL        = 16;
  localparam logic [4:0] NIL         = 5'd16;
  localparam int         RANDOM_N    = 284;
  localparam int         HOLD_AT     = 216;
  localparam int         HOLD_CYCLES = 250;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         TAIL_CYCLES = 40;

  // One row of stimulus; the pinned fields carry a hand-written expectation.
  typedef struct packed {
    logic                cmd;
    list_sel_t           sel;
    logic [HANDLE_W-1:0] hnd;
    logic                skip;
    logic                abrt;
    logic                pinned;
    kind_t               pin_kind;
    logic [4:0]          pin_count;
  } stim_row_t;

  typedef struct packed {
    kind_t               kind;
    logic [HANDLE_W-1:0] hnd;
    logic                last;
  } result_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                in_valid      = 1'b0;
  logic                cmd           = CMD_POST;
  logic [1:0]          list_sel      = LIST_INIT;
  logic [HANDLE_W-1:0] handle        = '0;
  logic                skip_on_abort = 1'b0;
  logic                aborting      = 1'b0;
  logic                out_ready     = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [1:0]          kind;
  logic [HANDLE_W-1:0] out_handle;
  logic                last;

  runlevel_callback_queue_pool dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .list_sel     (list_sel),
    .handle       (handle),
    .skip_on_abort(skip_on_abort),
    .aborting     (aborting),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .out_handle   (out_handle),
    .last         (last)
  );

  // Directed rows: an empty run, extreme handles, every list, a full pool and
  // its refusal, then runs that drain every list with and without aborting.
  stim_row_t directed_rows [26] = '{
    '{CMD_RUN,  LIST_INIT,        32'h0000_0000, 1'b0, 1'b1, 1'b1, KIND_DONE,   5'd1},
    '{CMD_POST, LIST_INIT,        32'h0000_0000, 1'b1, 1'b0, 1'b1, KIND_ACCEPT, 5'd1},
    '{CMD_POST, LIST_INIT,        32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, KIND_ACCEPT, 5'd1},
    '{CMD_POST, LIST_SHUTDOWN,    32'hA5A5_A5A5, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_BEFORE_EXIT, 32'h5A5A_5A5A, 1'b0, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_AFTER_EXIT,  32'h0000_0001, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_INIT,        32'h8000_0000, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_RUN,  LIST_INIT,        32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0, KIND_DONE,   5'd0},
    '{CMD_POST, LIST_INIT,        32'h0000_FFFF, 1'b0, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_SHUTDOWN,    32'hFFFF_0000, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_BEFORE_EXIT, 32'h00FF_00FF, 1'b0, 1'b1, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_AFTER_EXIT,  32'hFF00_FF00, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_INIT,        32'h0F0F_0F0F, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_SHUTDOWN,    32'hF0F0_F0F0, 1'b0, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_BEFORE_EXIT, 32'h3333_3333, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_AFTER_EXIT,  32'hCCCC_CCCC, 1'b0, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_INIT,        32'h5555_5555, 1'b0, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_SHUTDOWN,    32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_BEFORE_EXIT, 32'h1234_5678, 1'b0, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_AFTER_EXIT,  32'h8765_4321, 1'b1, 1'b0, 1'b0, KIND_ACCEPT, 5'd0},
    '{CMD_POST, LIST_SHUTDOWN,    32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, KIND_ACCEPT, 5'd1},
    '{CMD_POST, LIST_INIT,        32'hFEED_FACE, 1'b1, 1'b0, 1'b1, KIND_REJECT, 5'd1},
    '{CMD_RUN,  LIST_AFTER_EXIT,  32'h0000_0000, 1'b0, 1'b1, 1'b0, KIND_DONE,   5'd0},
    '{CMD_RUN,  LIST_INIT,        32'h0000_0000, 1'b0, 1'b0, 1'b0, KIND_DONE,   5'd0},
    '{CMD_RUN,  LIST_SHUTDOWN,    32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, KIND_DONE,   5'd0},
    '{CMD_RUN,  LIST_BEFORE_EXIT, 32'h0000_0000, 1'b0, 1'b0, 1'b0, KIND_DONE,   5'd0}
  };

  // Shadow of the pool: entry contents, links, list heads and the free list.
  logic [HANDLE_W-1:0] slot_handle [POOL];
  logic                slot_skip   [POOL];
  logic [4:0]          slot_link   [POOL];
  logic [4:0]          list_top    [4];
  logic [4:0]          init_end;
  logic [4:0]          free_top;

  result_t   due_results [$];
  stim_row_t pinned_rows [$];

  int  errors        = 0;
  int  offered_beats = 0;
  int  accepted_beats = 0;
  int  posts_seen    = 0;
  int  runs_seen     = 0;
  int  calls_due     = 0;
  int  refusals_due  = 0;
  int  quiet_cycles  = 0;
  bit  calm          = 1'b0;
  bit  held          = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Bring the shadow pool to its reset shape: one chain of free entries.
  task automatic pool_clear();
    for (int i = 0; i < POOL; i++) begin
      slot_handle[i] = '0;
      slot_skip[i]   = 1'b0;
      slot_link[i]   = 5'(i + 1);
    end
    for (int i = 0; i < 4; i++) list_top[i] = NIL;
    init_end = NIL;
    free_top = 5'd0;
  endtask

  // Work out the results of one accepted input beat and queue them.
  task automatic pool_forecast(input logic c, input list_sel_t s,
                               input logic [HANDLE_W-1:0] h, input logic sk,
                               input logic ab, output int made,
                               output kind_t closing);
    logic [4:0] e;
    logic [4:0] cur;
    logic [4:0] nxt;
    int         steps;
    made = 0;
    if (c == CMD_POST) begin
      posts_seen++;
      if (free_top == NIL) begin
        refusals_due++;
        closing = KIND_REJECT;
      end else begin
        e                   = free_top;
        free_top            = slot_link[e[3:0]];
        slot_handle[e[3:0]] = h;
        slot_skip[e[3:0]]   = sk;
        if (s == LIST_INIT) begin
          // Init entries are appended, so that list runs in posting order.
          slot_link[e[3:0]] = NIL;
          if (list_top[LIST_INIT] == NIL || init_end == NIL)
            list_top[LIST_INIT] = e;
          else
            slot_link[init_end[3:0]] = e;
          init_end = e;
        end else begin
          slot_link[e[3:0]] = list_top[s];
          list_top[s]       = e;
        end
        closing = KIND_ACCEPT;
      end
      due_results.push_back('{kind: closing, hnd: '0, last: 1'b1});
      made = 1;
    end else begin
      // A run detaches the list, then returns each walked entry to the pool.
      runs_seen++;
      cur         = list_top[s];
      list_top[s] = NIL;
      if (s == LIST_INIT) init_end = NIL;
      steps = 0;
      while (cur < NIL && steps < POOL) begin
        nxt = slot_link[cur[3:0]];
        if (!(ab && slot_skip[cur[3:0]])) begin
          due_results.push_back('{kind: KIND_CALL, hnd: slot_handle[cur[3:0]], last: 1'b0});
          calls_due++;
          made++;
        end
        slot_link[cur[3:0]] = free_top;
        free_top            = cur;
        cur                 = nxt;
        steps++;
      end
      closing = KIND_DONE;
      due_results.push_back('{kind: KIND_DONE, hnd: '0, last: 1'b1});
      made++;
    end
  endtask

  // Predict on every input beat and cross-check hand-written expectations.
  task automatic note_input_beat();
    stim_row_t row;
    int        made;
    kind_t     closing;
    row = pinned_rows.pop_front();
    pool_forecast(cmd, list_sel_t'(list_sel), handle, skip_on_abort, aborting,
                  made, closing);
    accepted_beats++;
    if (row.pinned && (closing != row.pin_kind || made != int'(row.pin_count))) begin
      $display("%0t: directed row: expected kind %0d in %0d results, got kind %0d in %0d",
               $time, row.pin_kind, row.pin_count, closing, made);
      errors++;
    end
  endtask

  // Compare one output beat with the oldest expectation.
  task automatic check_result_beat();
    result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result: kind %0d handle %h last %b",
               $time, kind, out_handle, last);
      errors++;
    end else begin
      want = due_results.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: kind: expected %0d, got %0d", $time, want.kind, kind);
        errors++;
      end
      if (out_handle !== want.hnd) begin
        $display("%0t: out_handle: expected %h, got %h", $time, want.hnd, out_handle);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last: expected %b, got %b", $time, want.last, last);
        errors++;
      end
    end
  endtask

  // Both channels are observed on the same edge; prediction comes first.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) note_input_beat();
      if (out_valid && out_ready) check_result_beat();
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: timed out after %0d quiet cycles", QUIET_LIMIT);
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Result side: occasional stalls, none while calm, and one long hold-off
  // once enough input beats have gone in.
  initial begin
    forever begin
      @(posedge clk);
      if (!held && accepted_beats >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // Present one beat and wait for it to be taken.
  task automatic offer(input stim_row_t r);
    pinned_rows.push_back(r);
    offered_beats++;
    cmd           <= r.cmd;
    list_sel      <= r.sel;
    handle        <= r.hnd;
    skip_on_abort <= r.skip;
    aborting      <= r.abrt;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Occasionally leave a gap before the next beat.
  task automatic maybe_gap();
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (accepted_beats != offered_beats || due_results.size() != 0)
      @(posedge clk);
  endtask

  // Mostly posts, so lists grow long and the pool fills now and then.
  function automatic stim_row_t random_row();
    stim_row_t r;
    int        roll;
    r      = '0;
    r.cmd  = ($urandom_range(99) < 72) ? CMD_POST : CMD_RUN;
    r.sel  = list_sel_t'($urandom_range(3));
    roll   = $urandom_range(99);
    if (roll < 6)
      r.hnd = '0;
    else if (roll < 12)
      r.hnd = '1;
    else
      r.hnd = $urandom;
    r.skip = 1'($urandom_range(1));
    r.abrt = 1'($urandom_range(1));
    return r;
  endfunction

  // Stimulus: reset, directed rows, then random beats in several phases.
  initial begin
    pool_clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      maybe_gap();
      offer(directed_rows[i]);
    end

    for (int n = 0; n < RANDOM_N; n++) begin
      if (n == 100) calm = 1'b1;
      if (n == 180) calm = 1'b0;
      // Hold back input until every outstanding result has been seen.
      if (n == 240) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      maybe_gap();
      offer(random_row());
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d posts (%0d refused on a full pool) and %0d runs", posts_seen,
             refusals_due, runs_seen);
    $display("tb: %0d callback results checked, with stalls and gaps on both sides",
             calls_due);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> runlevel_callback_queue_pool.f
+incdir+rtl/core
rtl/core/rcqp_pkg.sv
rtl/core/rcqp_front.sv
rtl/core/rcqp_back.sv
rtl/core/runlevel_callback_queue_pool.sv
sim/tb.sv
